/* hdl/ppa_pkg.sv */
// shared types, constants and plane selection for the planar polygon area block
package ppa_pkg;

    // fixed field widths
    localparam int NORM_W          = 16;
    localparam int SUM_W           = 64;
    localparam int AREA_W          = 63;
    localparam int CFG_IDX_W       = 2;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int QUEUE_DEPTH     = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 2'd2;

    localparam logic signed [NORM_W-1:0] NORMAL_Z_RESET = 16'sd16384;

    // projection planes
    typedef logic [1:0] t_plane;
    localparam t_plane PLANE_XY = 2'd0;
    localparam t_plane PLANE_XZ = 2'd1;
    localparam t_plane PLANE_YZ = 2'd2;

    // plane normal registers
    typedef struct packed {
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nz;
    } t_cfg;

    typedef struct packed {
        t_plane            plane;
        logic [NORM_W-1:0] dom;
    } t_pick;

    // magnitude of a normal component, -32768 maps to 32768
    function automatic logic [NORM_W-1:0] norm_mag(input logic signed [NORM_W-1:0] v);
        norm_mag = v[NORM_W-1] ? (~v + 1'b1) : v;
    endfunction

    // dominant component; x wins a tie with z, and a tie with y keeps the earlier choice
    function automatic t_pick pick_plane(input t_cfg cfg);
        logic [NORM_W-1:0] ax;
        logic [NORM_W-1:0] ay;
        logic [NORM_W-1:0] az;
        t_pick             p;
        ax = norm_mag(cfg.nx);
        ay = norm_mag(cfg.ny);
        az = norm_mag(cfg.nz);
        if (az > ax) begin
            p.plane = PLANE_XY;
            p.dom   = az;
        end else begin
            p.plane = PLANE_YZ;
            p.dom   = ax;
        end
        if (ay > p.dom) begin
            p.plane = PLANE_XZ;
            p.dom   = ay;
        end
        pick_plane = p;
    endfunction

endpackage

/* hdl/planar_polygon_area_3d.sv */
// planar polygon area: top level with normal registers and stream ports
// vertex words are taken one per cycle while the queue has room; each costs two products
// and a saturating add; the area word is offered once its closing vertex has passed the
// scaling unit: squaring, root, multiply and bit serial divide, all skipped with a zero normal
// a following polygon keeps streaming meanwhile until its own closing vertex waits
// reset is synchronous, active low; normal resets to (0, 0, 1.0) and the sum to zero
module planar_polygon_area_3d
    import ppa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration writes
    input  logic                                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [NORM_W-1:0]                      i_cfg_data,
    // vertex stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // fields from bit 0: vertex_x, vertex_y, vertex_z, zero fill
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                   s_axis_tlast,
    // area stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // fields from bit 0: area, zero fill
    output logic [SUM_W-1:0]                       m_axis_tdata,
    // fields from bit 0: zero_normal
    output logic                                   m_axis_tuser
);
    localparam int CW = COORD_WIDTH;
    localparam int QW = 4 * CW + 2;

    t_cfg r_cfg;

    logic          q_push;
    logic [QW-1:0] q_in;
    logic          q_full;
    logic          q_pop;
    logic [QW-1:0] q_out;
    logic          q_valid;

    logic                    sc_busy;
    logic                    sc_start;
    logic signed [SUM_W-1:0] sc_sum;
    logic [AREA_W-1:0]       area;

    // normal registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nx <= '0;
            r_cfg.ny <= '0;
            r_cfg.nz <= NORMAL_Z_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NORMAL_X: r_cfg.nx <= i_cfg_data;
                REG_NORMAL_Y: r_cfg.ny <= i_cfg_data;
                REG_NORMAL_Z: r_cfg.nz <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ppa_front #(
        .COORD_WIDTH (CW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_x     (s_axis_tdata[CW-1:0]),
        .i_y     (s_axis_tdata[2*CW-1:CW]),
        .i_z     (s_axis_tdata[3*CW-1:2*CW]),
        .i_close (s_axis_tlast),
        .o_push  (q_push),
        .o_data  (q_in),
        .i_full  (q_full)
    );

    ppa_fifo #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_valid (q_valid)
    );

    ppa_accum #(
        .COORD_WIDTH (CW)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (q_valid),
        .i_data       (q_out),
        .o_pop        (q_pop),
        .i_scale_busy (sc_busy),
        .o_start      (sc_start),
        .o_sum        (sc_sum)
    );

    ppa_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (sc_start),
        .i_sum   (sc_sum),
        .o_busy  (sc_busy),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_area  (area),
        .o_zero  (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, area};

endmodule

/* hdl/ppa_fifo.sv */
// small register queue between the vertex front end and the accumulator
module ppa_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_valid
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* hdl/ppa_front.sv */
// front end: takes vertex words, picks the plane and forms cross term operands
module ppa_front
    import ppa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [COORD_WIDTH-1:0]   i_x,
    input  logic [COORD_WIDTH-1:0]   i_y,
    input  logic [COORD_WIDTH-1:0]   i_z,
    input  logic                     i_close,
    output logic                     o_push,
    output logic [4*COORD_WIDTH+1:0] o_data,
    input  logic                     i_full
);
    localparam int CW = COORD_WIDTH;

    logic [CW-1:0] r_prev_x;
    logic [CW-1:0] r_prev_y;
    logic [CW-1:0] r_prev_z;
    logic          r_have_prev;

    t_pick         pick;
    logic [CW-1:0] cur_a;
    logic [CW-1:0] cur_b;
    logic [CW-1:0] prev_a;
    logic [CW-1:0] prev_b;
    logic          accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign pick    = pick_plane(i_cfg);

    // coordinate pair of the projection plane
    always_comb begin
        case (pick.plane)
            PLANE_XY: begin
                cur_a  = i_x;      cur_b  = i_y;
                prev_a = r_prev_x; prev_b = r_prev_y;
            end
            PLANE_XZ: begin
                cur_a  = i_x;      cur_b  = i_z;
                prev_a = r_prev_x; prev_b = r_prev_z;
            end
            default: begin
                cur_a  = i_y;      cur_b  = i_z;
                prev_a = r_prev_y; prev_b = r_prev_z;
            end
        endcase
    end

    // queue word: close, has_prev, b_prev, a_cur, b_cur, a_prev (low bits)
    assign o_data = {i_close, r_have_prev, prev_b, cur_a, cur_b, prev_a};

    // previous vertex
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_x <= i_x;
            r_prev_y <= i_y;
            r_prev_z <= i_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
        end else if (accept) begin
            r_have_prev <= !i_close;
        end
    end

endmodule

/* hdl/ppa_accum.sv */
// back end pipeline: cross term products and saturating accumulation
module ppa_accum
    import ppa_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [4*COORD_WIDTH+1:0] i_data,
    output logic                     o_pop,
    input  logic                     i_scale_busy,
    output logic                     o_start,
    output logic signed [SUM_W-1:0]  o_sum
);
    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW;

    logic signed [CW-1:0] q_a_prev;
    logic signed [CW-1:0] q_b_cur;
    logic signed [CW-1:0] q_a_cur;
    logic signed [CW-1:0] q_b_prev;
    logic                 q_has_prev;
    logic                 q_close;

    logic                 r_m_valid;
    logic                 r_m_term;
    logic                 r_m_close;
    logic signed [PW-1:0] r_p0;
    logic signed [PW-1:0] r_p1;
    logic signed [SUM_W-1:0] r_sum;

    logic                 a_take;
    logic signed [PW:0]   term;
    logic signed [SUM_W:0] wide;
    logic signed [SUM_W-1:0] n_sum;

    assign q_a_prev   = i_data[CW-1:0];
    assign q_b_cur    = i_data[2*CW-1:CW];
    assign q_a_cur    = i_data[3*CW-1:2*CW];
    assign q_b_prev   = i_data[4*CW-1:3*CW];
    assign q_has_prev = i_data[4*CW];
    assign q_close    = i_data[4*CW+1];

    // a closing word waits for the scaling unit
    assign a_take  = r_m_valid && (!r_m_close || !i_scale_busy);
    assign o_pop   = i_valid && (!r_m_valid || a_take);
    assign o_start = a_take && r_m_close;

    // product stage
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p0      <= q_a_prev * q_b_cur;
            r_p1      <= q_a_cur * q_b_prev;
            r_m_term  <= q_has_prev;
            r_m_close <= q_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (o_pop) begin
            r_m_valid <= 1'b1;
        end else if (a_take) begin
            r_m_valid <= 1'b0;
        end
    end

    // saturating add of the cross term
    always_comb begin
        term = {r_p0[PW-1], r_p0} - {r_p1[PW-1], r_p1};
        wide = {r_sum[SUM_W-1], r_sum} + {{(SUM_W - PW){term[PW]}}, term};
        if (!r_m_term) begin
            n_sum = r_sum;
        end else if (wide[SUM_W] != wide[SUM_W-1]) begin
            n_sum = wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            n_sum = wide[SUM_W-1:0];
        end
    end

    assign o_sum = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (a_take) begin
            r_sum <= r_m_close ? '0 : n_sum;
        end
    end

endmodule

/* hdl/ppa_scale.sv */
// per polygon scaling: norm square root, wide product and bit serial divide
module ppa_scale
    import ppa_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_sum,
    output logic                    o_busy,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [AREA_W-1:0]       o_area,
    output logic                    o_zero
);
    localparam int ROOT_W    = NORM_W;
    localparam int N2_W      = 2 * NORM_W;
    localparam int REM_W     = ROOT_W + 1;
    localparam int DQ_W      = SUM_W + ROOT_W;
    localparam int HALF_W    = SUM_W / 2;
    localparam int DIV_W     = NORM_W + 1;
    localparam int CNT_W     = $clog2(DQ_W);
    localparam int SQRT_LAST = ROOT_W - 1;
    localparam int DIV_LAST  = DQ_W - 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SQRT = 3'd2;
    localparam logic [2:0] S_MLO  = 3'd3;
    localparam logic [2:0] S_MHI  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_a;
    logic [NORM_W-1:0]   r_dom;
    logic [N2_W-1:0]     r_n2;
    logic [ROOT_W-1:0]   r_root;
    logic [REM_W-1:0]    r_rem;
    logic [DQ_W-1:0]     r_dq;
    logic [AREA_W-1:0]   r_res_area;
    logic                r_res_zero;
    logic                r_o_valid;
    logic [AREA_W-1:0]   r_area;
    logic                r_zero;

    t_pick                   pick;
    logic [SUM_W-1:0]        sum_abs;
    logic signed [NORM_W-1:0] sq_sel;
    logic [N2_W-1:0]         sq;
    logic [REM_W+1:0]        sqrt_sh;
    logic [REM_W+1:0]        sqrt_trial;
    logic                    sqrt_ge;
    logic [HALF_W-1:0]       mul_a;
    logic [HALF_W+ROOT_W-1:0] mul_p;
    logic [DIV_W-1:0]        div_d;
    logic [DIV_W:0]          div_sh;
    logic                    div_ge;
    logic                    out_free;

    assign pick     = pick_plane(i_cfg);
    assign sum_abs  = i_sum[SUM_W-1] ? (~i_sum + 1'b1) : i_sum;
    assign o_busy   = (r_state != S_IDLE);
    assign out_free = !r_o_valid || i_ready;

    // one squarer, three components in turn
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sq_sel = i_cfg.nx;
            2'd1:    sq_sel = i_cfg.ny;
            default: sq_sel = i_cfg.nz;
        endcase
        sq = N2_W'(sq_sel * sq_sel);
    end

    // one root bit per cycle
    assign sqrt_sh    = {r_rem, r_n2[N2_W-1:N2_W-2]};
    assign sqrt_trial = {1'b0, r_root, 2'b01};
    assign sqrt_ge    = (sqrt_sh >= sqrt_trial);

    // shared 32 by 16 multiplier for both halves of the sum
    assign mul_a = (r_state == S_MLO) ? r_a[HALF_W-1:0] : r_a[SUM_W-1:HALF_W];
    assign mul_p = mul_a * r_root;

    // restoring divide by twice the dominant component
    assign div_d  = {r_dom, 1'b0};
    assign div_sh = {r_rem, r_dq[DQ_W-1]};
    assign div_ge = (div_sh >= {1'b0, div_d});

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) begin
                        r_state <= (pick.dom == '0) ? S_DONE : S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_cnt == CNT_W'(2)) begin
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SQRT: begin
                    if (r_cnt == CNT_W'(SQRT_LAST)) begin
                        r_cnt   <= '0;
                        r_state <= S_MLO;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MLO: begin
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_LAST)) begin
                        r_cnt   <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a        <= sum_abs;
                r_dom      <= pick.dom;
                r_n2       <= '0;
                r_root     <= '0;
                r_rem      <= '0;
                r_res_area <= '0;
                r_res_zero <= (pick.dom == '0);
            end
            S_SQ: begin
                r_n2 <= r_n2 + sq;
            end
            S_SQRT: begin
                r_n2 <= {r_n2[N2_W-3:0], 2'b00};
                if (sqrt_ge) begin
                    r_rem  <= REM_W'(sqrt_sh - sqrt_trial);
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= REM_W'(sqrt_sh);
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
            end
            S_MLO: begin
                r_dq  <= DQ_W'(mul_p);
                r_rem <= '0;
            end
            S_MHI: begin
                r_dq <= r_dq + {mul_p, {HALF_W{1'b0}}};
            end
            S_DIV: begin
                r_rem <= div_ge ? REM_W'(div_sh - {1'b0, div_d}) : REM_W'(div_sh);
                r_dq  <= {r_dq[DQ_W-2:0], div_ge};
                if (r_cnt == CNT_W'(DIV_LAST)) begin
                    // quotient of 2^63 or more saturates
                    if (|r_dq[DQ_W-2:AREA_W-1]) begin
                        r_res_area <= '1;
                    end else begin
                        r_res_area <= {r_dq[AREA_W-2:0], div_ge};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_area <= r_res_area;
            r_zero <= r_res_zero;
        end
    end

    assign o_valid = r_o_valid;
    assign o_area  = r_area;
    assign o_zero  = r_zero;

    // a zero dominant component always reports zero area
    a_zero_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_zero |-> r_area == '0)
        else $error("zero normal result with nonzero area");

    // a new polygon is only handed over while the unit is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("start while scaling unit busy");

    // a fresh result only comes out of the done state
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_o_valid ##1 r_o_valid |-> $past(r_state) == S_DONE)
        else $error("result loaded outside done state");

    // the divide runs its full count before finishing
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt != CNT_W'(DIV_LAST) |=> r_state == S_DIV)
        else $error("divide left early");

endmodule

/* bench/planar_polygon_area_3d_tb.sv */
// self-checking testbench for the planar polygon area block: vertex stream in, area stream out
`timescale 1ns / 100ps

module planar_polygon_area_3d_tb
    import ppa_pkg::*;
();

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int TDATA_W      = ((3 * CW + 7) / 8) * 8;
    localparam int DRAIN_CYCLES = 150;
    localparam int MAX_REPORTS  = 10;
    localparam int RUN_LIMIT_NS = 10_000_000;

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};
    localparam longint               SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint               SUM_MIN   = -SUM_MAX - 1;
    localparam logic [AREA_W-1:0]    AREA_MAX  = '1;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 closing;
    } t_vertex_word;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic              zero_normal;
    } t_area_word;

    // ports
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [NORM_W-1:0]    i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // fields from bit 0: vertex_x, vertex_y, vertex_z, zero fill
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // fields from bit 0: area, zero fill
    logic [SUM_W-1:0]     m_axis_tdata;
    // fields from bit 0: zero_normal
    logic                 m_axis_tuser;

    // stimulus and expected area words
    t_vertex_word vertex_q[$];
    t_area_word   area_q[$];
    t_vertex_word send_v;
    t_vertex_word seen_v;
    bit           vtx_took      = 1'b0;
    int           idle_pct      = 13;
    int           errors        = 0;
    int           vertex_words  = 0;
    int           area_words    = 0;
    int           normal_writes = 0;

    // shadow of the normal registers and the shoelace accumulator
    t_cfg   normal_cfg = '{nx: 16'sd0, ny: 16'sd0, nz: NORMAL_Z_RESET};
    longint prev_x     = 0;
    longint prev_y     = 0;
    longint prev_z     = 0;
    bit     have_prev  = 1'b0;
    longint cross_sum  = 0;

    planar_polygon_area_3d DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // magnitude of a normal component, 17 bits so that the most negative value fits
    function automatic logic [NORM_W:0] comp_mag(input logic signed [NORM_W-1:0] v);
        int t;
        t = v;
        if (t < 0) t = -t;
        return t[NORM_W:0];
    endfunction

    // floor square root, bit by bit from the top
    function automatic logic [16:0] norm_root(input longint n);
        logic [16:0] r;
        logic [16:0] t;
        int          b;
        r = '0;
        for (b = 16; b >= 0; b--) begin
            t = r | (17'd1 << b);
            if (longint'(t) * longint'(t) <= n) r = t;
        end
        return r;
    endfunction

    // accumulate one vertex word and queue the area word that a closing vertex yields
    task automatic shoelace_accept(input t_vertex_word v);
        longint          cx;
        longint          cy;
        longint          cz;
        longint          term;
        longint          sum_next;
        longint          nxl;
        longint          nyl;
        longint          nzl;
        logic [NORM_W:0] ax;
        logic [NORM_W:0] ay;
        logic [NORM_W:0] az;
        logic [NORM_W:0] dom;
        t_plane          plane;
        logic [63:0]     mag_sum;
        logic [127:0]    scaled;
        logic [127:0]    quot;
        t_area_word      res;
        cx = v.x;
        cy = v.y;
        cz = v.z;
        ax = comp_mag(normal_cfg.nx);
        ay = comp_mag(normal_cfg.ny);
        az = comp_mag(normal_cfg.nz);
        // dominant component, x wins a tie with z, a tie with y keeps the earlier pick
        if (az > ax) begin
            plane = PLANE_XY;
            dom   = az;
        end else begin
            plane = PLANE_YZ;
            dom   = ax;
        end
        if (ay > dom) begin
            plane = PLANE_XZ;
            dom   = ay;
        end
        // cross term of the held and the new corner, saturating sum
        if (have_prev) begin
            case (plane)
                PLANE_XY: term = prev_x * cy - cx * prev_y;
                PLANE_YZ: term = prev_y * cz - cy * prev_z;
                default:  term = prev_x * cz - cx * prev_z;
            endcase
            sum_next = cross_sum + term;
            if (cross_sum[63] == term[63] && sum_next[63] != term[63])
                sum_next = term[63] ? SUM_MIN : SUM_MAX;
            cross_sum = sum_next;
        end
        prev_x    = cx;
        prev_y    = cy;
        prev_z    = cz;
        have_prev = 1'b1;
        if (v.closing) begin
            res.area        = '0;
            res.zero_normal = 1'b0;
            if (dom == 0) begin
                res.zero_normal = 1'b1;
            end else begin
                // |sum| * |n| / (2 * |n_dominant|), truncated, clipped to 63 bits
                nxl      = normal_cfg.nx;
                nyl      = normal_cfg.ny;
                nzl      = normal_cfg.nz;
                mag_sum  = cross_sum[63] ? 64'(-cross_sum) : 64'(cross_sum);
                scaled   = 128'(mag_sum) * 128'(norm_root(nxl * nxl + nyl * nyl + nzl * nzl));
                quot     = scaled / 128'({dom, 1'b0});
                res.area = (quot > AREA_MAX) ? AREA_MAX : quot[AREA_W-1:0];
            end
            area_q    = {area_q, res};
            cross_sum = 0;
            have_prev = 1'b0;
        end
    endtask

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endtask

    // compare one area word against the oldest expectation
    task automatic check_area(input logic [AREA_W-1:0] got_area, input logic got_zero);
        t_area_word want;
        if (area_q.size() == 0) begin
            note_error($sformatf("unexpected area word: area %0d zero_normal %0b",
                got_area, got_zero));
            return;
        end
        want = area_q.pop_front();
        if (want.area !== got_area)
            note_error($sformatf("area: expected %0d, got %0d", want.area, got_area));
        if (want.zero_normal !== got_zero)
            note_error($sformatf("zero_normal: expected %0b, got %0b",
                want.zero_normal, got_zero));
    endtask

    // monitor: results first, then the accepted vertex word
    always @(posedge i_clk) begin
        vtx_took = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            area_words++;
            check_area(m_axis_tdata[AREA_W-1:0], m_axis_tuser);
        end
        if (vtx_took) begin
            seen_v.x       = s_axis_tdata[CW-1:0];
            seen_v.y       = s_axis_tdata[2*CW-1:CW];
            seen_v.z       = s_axis_tdata[3*CW-1:2*CW];
            seen_v.closing = s_axis_tlast;
            vertex_words++;
            shoelace_accept(seen_v);
        end
    end

    // vertex driver with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || vtx_took)) begin
            if (vertex_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                send_v = vertex_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= TDATA_W'({send_v.z, send_v.y, send_v.x});
                s_axis_tlast  <= send_v.closing;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // area receiver with random stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic push_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                               input logic signed [CW-1:0] z, input logic closing);
        t_vertex_word w;
        w.x       = x;
        w.y       = y;
        w.z       = z;
        w.closing = closing;
        vertex_q  = {vertex_q, w};
    endtask

    // mix of full range, extreme and small coordinates
    function automatic logic signed [CW-1:0] rand_coord();
        int pick;
        pick = $urandom_range(5);
        if (pick == 0) return CW'($urandom);
        if (pick == 1) begin
            pick = $urandom_range(3);
            if (pick == 0) return COORD_MAX;
            if (pick == 1) return COORD_MIN;
            if (pick == 2) return '0;
            return '1;
        end
        return CW'($urandom_range(8191)) - CW'(4096);
    endfunction

    function automatic t_vertex_word rand_vertex(input logic closing);
        t_vertex_word w;
        w.x       = rand_coord();
        w.y       = rand_coord();
        w.z       = rand_coord();
        w.closing = closing;
        return w;
    endfunction

    // one polygon, mostly closed on its first corner; returns the words queued
    function automatic int queue_polygon();
        t_vertex_word first;
        int           corners;
        int           kind;
        int           k;
        kind     = $urandom_range(19);
        corners  = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 3);
        first    = rand_vertex(1'b0);
        vertex_q = {vertex_q, first};
        for (k = 1; k < corners; k++) vertex_q = {vertex_q, rand_vertex(1'b0)};
        if (kind >= 2) begin
            first.closing = 1'b1;
            vertex_q      = {vertex_q, first};
            corners++;
            // closing word with nothing held
            if (kind == 2) begin
                vertex_q = {vertex_q, rand_vertex(1'b1)};
                corners++;
            end
        end else if (kind == 1) begin
            // broken: closed on a stray corner
            vertex_q = {vertex_q, rand_vertex(1'b1)};
            corners++;
        end
        // otherwise left open, merging into the next polygon
        return corners;
    endfunction

    task automatic queue_random_words(input int words);
        int queued;
        queued = 0;
        while (queued < words) queued += queue_polygon();
    endtask

    task automatic load_normal(input logic signed [NORM_W-1:0] nx,
                               input logic signed [NORM_W-1:0] ny,
                               input logic signed [NORM_W-1:0] nz);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_NORMAL_X;
        i_cfg_data <= nx;
        @(negedge i_clk);
        i_cfg_idx  <= REG_NORMAL_Y;
        i_cfg_data <= ny;
        @(negedge i_clk);
        i_cfg_idx  <= REG_NORMAL_Z;
        i_cfg_data <= nz;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        normal_cfg.nx = nx;
        normal_cfg.ny = ny;
        normal_cfg.nz = nz;
        normal_writes++;
    endtask

    // hold off until every queued word is sent and every area word is back
    task automatic settle();
        while (vertex_q.size() != 0 || s_axis_tvalid || area_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        int ph;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // closing word with no corner held, under the reset normal
        push_vertex(256, 512, 768, 1'b1);
        // full scale triangle
        push_vertex(COORD_MAX, COORD_MIN, 0, 1'b0);
        push_vertex(COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
        push_vertex(COORD_MAX, COORD_MAX, COORD_MIN, 1'b0);
        push_vertex(COORD_MAX, COORD_MIN, 0, 1'b1);
        // unit square
        push_vertex(0, 0, 0, 1'b0);
        push_vertex(256, 0, 0, 1'b0);
        push_vertex(256, 256, 0, 1'b0);
        push_vertex(0, 256, 0, 1'b0);
        push_vertex(0, 0, 0, 1'b1);
        settle();

        // all-zero normal
        load_normal(0, 0, 0);
        push_vertex(0, 0, 0, 1'b0);
        push_vertex(512, 0, 0, 1'b0);
        push_vertex(0, 512, 0, 1'b0);
        push_vertex(0, 0, 0, 1'b1);
        settle();

        // three-way tie falls to the yz plane
        load_normal(8192, 8192, 8192);
        push_vertex(0, 0, 0, 1'b0);
        push_vertex(0, 256, 0, 1'b0);
        push_vertex(0, 0, 256, 1'b0);
        push_vertex(0, 0, 0, 1'b1);
        // normal change halfway through a polygon
        push_vertex(0, 0, 0, 1'b0);
        push_vertex(256, 0, 0, 1'b0);
        settle();
        load_normal(0, -16384, 0);
        push_vertex(256, 0, 512, 1'b0);
        push_vertex(0, 0, 512, 1'b0);
        push_vertex(0, 0, 0, 1'b1);

        // random polygons under a range of normals
        for (ph = 0; ph < 9; ph++) begin
            settle();
            case (ph)
                0: load_normal(0, 0, 16384);
                1: load_normal(16384, 0, 0);
                2: load_normal(0, -16384, 0);
                3: load_normal(32767, -32768, 32767);
                4: load_normal(-32768, 0, -32768);
                7: load_normal(1, 0, -1);
                8: load_normal(0, 0, 0);
                default: load_normal(NORM_W'($urandom), NORM_W'($urandom), NORM_W'($urandom));
            endcase
            idle_pct = (ph == 6) ? 0 : 13;
            queue_random_words((ph == 8) ? 60 : 240);
        end
        settle();
        idle_pct = 13;

        if (area_q.size() != 0)
            note_error($sformatf("%0d area words never arrived", area_q.size()));
        $display("covered %0d vertex words and %0d area words over %0d normal settings",
            vertex_words, area_words, normal_writes);
        $display("planes xy, xz, yz, ties, zero normal, open and stray closings; %0d mismatches",
            errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
